// ===== hw/rtl/nt2p_pkg.sv =====
// Package for the note-to-pitch converter.
// Holds the shared constants, field widths, the split result type and the
// multiplier operation codes. No dependencies.
`timescale 1ns / 1ps

package nt2p_pkg;

    localparam int KEY_W    = 7;
    localparam int POS_W    = 14;   // key and fraction joined, 1/128 semitone
    localparam int REM_W    = 11;   // remainder within one octave
    localparam int OCT_W    = 4;
    localparam int STEP_W   = 6;    // quarter-semitone steps, 0 to 47
    localparam int FRAC_W   = 5;    // 1/32 of a step
    localparam int BASE_W   = 16;
    localparam int FAC_W    = 14;   // 2.12 step factor
    localparam int PT_W     = 30;   // base times factor
    localparam int DIFF_W   = PT_W - FRAC_W;
    localparam int PROD_W   = DIFF_W + BASE_W;
    localparam int SUM_W    = 32;
    localparam int PITCH_W  = 14;

    localparam logic [REM_W-1:0]   OCTAVE_UNITS = 11'd1536;
    localparam logic [BASE_W-1:0]  STEP_FACTOR  = 16'h103B;
    localparam logic [BASE_W-1:0]  UNITY_PITCH  = 16'h1000;
    localparam logic [PITCH_W-1:0] PITCH_MAX    = 14'h3FFF;
    localparam logic [19:0]        PITCH_LIMIT  = 20'h04000;

    // Octave split of one key difference.
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [STEP_W-1:0] steps;
        logic [FRAC_W-1:0] frac;
        logic              ovf;     // four or more octaves up
    } t_split;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_STEP,   // factor times step constant
        MUL_LO,     // base times previous factor
        MUL_HI,     // base times current factor
        MUL_FRAC    // scaled difference times fraction
    } t_mul_op;

endpackage

// ===== hw/rtl/nt2p_split.sv =====
// Octave split: turns the distance between two notes into a shifted base
// pitch, a step count and a fraction. Depends on nt2p_pkg.
`timescale 1ns / 1ps

module nt2p_split (
    input  logic [nt2p_pkg::POS_W-1:0] i_mag,
    input  logic                       i_down,
    output nt2p_pkg::t_split           o_split
);

    logic [8:0]                  w_q_mul;
    logic [nt2p_pkg::OCT_W-1:0]  w_oct;
    logic [nt2p_pkg::OCT_W-1:0]  w_oct_adj;
    logic [4:0]                  w_oct3;
    logic [nt2p_pkg::POS_W-1:0]  w_rem_raw;
    logic [nt2p_pkg::REM_W-1:0]  w_rem;
    logic [nt2p_pkg::REM_W-1:0]  w_rem_adj;

    // Division by 1536 is division of the top five bits by three; the
    // reciprocal 11/32 is exact over that range.
    assign w_q_mul   = {4'b0, i_mag[13:9]} * 9'd11;
    assign w_oct     = w_q_mul[8:5];
    assign w_oct3    = {1'b0, w_oct} * 5'd3;
    assign w_rem_raw = i_mag - {w_oct3, 9'b0};
    assign w_rem     = w_rem_raw[nt2p_pkg::REM_W-1:0];

    always_comb begin
        w_oct_adj = w_oct;
        w_rem_adj = w_rem;
        if (i_down && (w_rem != '0)) begin
            // A downward distance that is not whole octaves borrows one.
            w_oct_adj = w_oct + 4'd1;
            w_rem_adj = nt2p_pkg::OCTAVE_UNITS - w_rem;
        end
    end

    always_comb begin
        o_split.steps = w_rem_adj[nt2p_pkg::REM_W-1:nt2p_pkg::FRAC_W];
        o_split.frac  = w_rem_adj[nt2p_pkg::FRAC_W-1:0];
        o_split.ovf   = !i_down && (w_oct_adj >= 4'd4);
        if (i_down) begin
            o_split.base = (w_oct_adj >= 4'd13) ? '0 : (nt2p_pkg::UNITY_PITCH >> w_oct_adj);
        end else begin
            o_split.base = nt2p_pkg::UNITY_PITCH << w_oct_adj[1:0];
        end
    end

endmodule

// ===== hw/rtl/nt2p_mul.sv =====
// Shared multiplier of the converter with its operand selection.
// Depends on nt2p_pkg.
`timescale 1ns / 1ps

module nt2p_mul (
    input  nt2p_pkg::t_mul_op            i_op,
    input  logic [nt2p_pkg::FAC_W-1:0]   i_cur,
    input  logic [nt2p_pkg::FAC_W-1:0]   i_prev,
    input  logic [nt2p_pkg::BASE_W-1:0]  i_base,
    input  logic [nt2p_pkg::DIFF_W-1:0]  i_diff,
    input  logic [nt2p_pkg::FRAC_W-1:0]  i_frac,
    output logic [nt2p_pkg::PROD_W-1:0]  o_prod
);

    logic [nt2p_pkg::DIFF_W-1:0] w_a;
    logic [nt2p_pkg::BASE_W-1:0] w_b;

    always_comb begin
        unique case (i_op)
            nt2p_pkg::MUL_STEP: begin
                w_a = {{(nt2p_pkg::DIFF_W-nt2p_pkg::FAC_W){1'b0}}, i_cur};
                w_b = nt2p_pkg::STEP_FACTOR;
            end
            nt2p_pkg::MUL_LO: begin
                w_a = {{(nt2p_pkg::DIFF_W-nt2p_pkg::FAC_W){1'b0}}, i_prev};
                w_b = i_base;
            end
            nt2p_pkg::MUL_HI: begin
                w_a = {{(nt2p_pkg::DIFF_W-nt2p_pkg::FAC_W){1'b0}}, i_cur};
                w_b = i_base;
            end
            nt2p_pkg::MUL_FRAC: begin
                w_a = i_diff;
                w_b = {{(nt2p_pkg::BASE_W-nt2p_pkg::FRAC_W){1'b0}}, i_frac};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign o_prod = {{nt2p_pkg::BASE_W{1'b0}}, w_a} * {{nt2p_pkg::DIFF_W{1'b0}}, w_b};

endmodule

// ===== hw/rtl/note_to_pitch_convert.sv =====
// Top level of the note-to-pitch converter: sequencer, registers and the
// output stage. Depends on nt2p_pkg, nt2p_split and nt2p_mul.
`timescale 1ns / 1ps

// The block converts a target note (key plus fine tune in 1/128 semitone)
// into a 2.12 sample step rate relative to a center note that plays at unity
// rate 0x1000. One transaction is taken at a time: after acceptance the
// distance is split into octaves, a quarter-semitone factor is raised step by
// step through a single shared multiplier, the two neighboring points are
// formed and interpolated with the same multiplier, and the result saturates
// at 0x3FFF with the clipped flag set. The step loop through the shared
// multiplier runs once per step, where steps is the remainder within the
// octave divided by 32 (0 to 47). Four or more octaves upward saturate at
// once and skip the step loop. The finished result sits in an output
// register, so the next transaction is accepted while it waits to be taken;
// a result that finishes while the previous one is still waiting holds the
// block in its last step until the output register frees up.
module note_to_pitch_convert (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [nt2p_pkg::KEY_W-1:0]    i_center_key,
    input  logic [nt2p_pkg::KEY_W-1:0]    i_center_fraction,
    input  logic [nt2p_pkg::KEY_W-1:0]    i_target_key,
    input  logic [nt2p_pkg::KEY_W-1:0]    i_target_fraction,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [nt2p_pkg::PITCH_W-1:0]  o_pitch_value,
    output logic                          o_clipped
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_STEP,
        S_LO,
        S_HI,
        S_INT,
        S_FIN
    } t_state;

    t_state                          r_state;
    logic [nt2p_pkg::POS_W-1:0]      r_mag;
    logic                            r_down;
    nt2p_pkg::t_split                r_split;
    logic [nt2p_pkg::STEP_W-1:0]     r_cnt;
    logic [nt2p_pkg::FAC_W-1:0]      r_cur;
    logic [nt2p_pkg::FAC_W-1:0]      r_prev;
    logic [nt2p_pkg::PT_W-1:0]       r_lo;
    logic [nt2p_pkg::PT_W-1:0]       r_hi;
    logic [nt2p_pkg::SUM_W-1:0]      r_sum;
    logic                            r_out_valid;
    logic [nt2p_pkg::PITCH_W-1:0]    r_pitch;
    logic                            r_clip;

    logic [nt2p_pkg::POS_W-1:0]      w_cpos;
    logic [nt2p_pkg::POS_W-1:0]      w_tpos;
    logic                            w_in_acc;
    logic                            w_out_acc;
    logic                            w_fin_load;
    nt2p_pkg::t_split                w_split;
    nt2p_pkg::t_mul_op               w_op;
    logic [nt2p_pkg::PT_W-1:0]       w_diff;
    logic [nt2p_pkg::PROD_W-1:0]     w_prod;
    logic [19:0]                     w_pitch_full;
    logic                            w_clip;

    assign w_cpos    = {i_center_key, i_center_fraction};
    assign w_tpos    = {i_target_key, i_target_fraction};
    assign o_stall   = (r_state != S_IDLE);
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_out_valid && !i_stall;

    // The finished result moves to the output register once it is empty or
    // its current contents are taken at this edge.
    assign w_fin_load = (r_state == S_FIN) && (!r_out_valid || !i_stall);

    nt2p_split u_split (
        .i_mag   (r_mag),
        .i_down  (r_down),
        .o_split (w_split)
    );

    // The operand choice follows the state; the product is combinational.
    always_comb begin
        unique case (r_state)
            S_LO:    w_op = nt2p_pkg::MUL_LO;
            S_HI:    w_op = nt2p_pkg::MUL_HI;
            S_INT:   w_op = nt2p_pkg::MUL_FRAC;
            default: w_op = nt2p_pkg::MUL_STEP;
        endcase
    end

    // The factor never decreases, so the high point is never below the low.
    assign w_diff = r_hi - r_lo;

    nt2p_mul u_mul (
        .i_op   (w_op),
        .i_cur  (r_cur),
        .i_prev (r_prev),
        .i_base (r_split.base),
        .i_diff (w_diff[nt2p_pkg::PT_W-1:nt2p_pkg::FRAC_W]),
        .i_frac (r_split.frac),
        .o_prod (w_prod)
    );

    // The interpolated value is kept to 32 bits; the pitch is its upper part.
    assign w_pitch_full = r_sum[nt2p_pkg::SUM_W-1:12];
    assign w_clip       = r_split.ovf || (w_pitch_full >= nt2p_pkg::PITCH_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fin_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_down  <= (w_tpos < w_cpos);
                        r_mag   <= (w_tpos < w_cpos) ? (w_cpos - w_tpos) : (w_tpos - w_cpos);
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    r_split <= w_split;
                    r_cnt   <= '0;
                    r_prev  <= nt2p_pkg::UNITY_PITCH[nt2p_pkg::FAC_W-1:0];
                    r_cur   <= nt2p_pkg::STEP_FACTOR[nt2p_pkg::FAC_W-1:0];
                    r_state <= w_split.ovf ? S_FIN : S_STEP;
                end
                S_STEP: begin
                    if (r_cnt == r_split.steps) begin
                        r_state <= S_LO;
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= w_prod[12 +: nt2p_pkg::FAC_W];
                        r_cnt  <= r_cnt + 1'b1;
                    end
                end
                S_LO: begin
                    r_lo    <= w_prod[nt2p_pkg::PT_W-1:0];
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_hi    <= w_prod[nt2p_pkg::PT_W-1:0];
                    r_state <= S_INT;
                end
                S_INT: begin
                    r_sum   <= {{(nt2p_pkg::SUM_W-nt2p_pkg::PT_W){1'b0}}, r_lo}
                               + w_prod[nt2p_pkg::SUM_W-1:0];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // Hold here while an earlier result is still not taken.
                    if (w_fin_load) begin
                        r_clip      <= w_clip;
                        r_pitch     <= w_clip ? nt2p_pkg::PITCH_MAX
                                              : w_pitch_full[nt2p_pkg::PITCH_W-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pitch_value = r_pitch;
    assign o_clipped     = r_clip;

    // A clipped result always carries the saturated pitch.
    a_clip_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_clipped || (o_pitch_value == nt2p_pkg::PITCH_MAX)))
        else $error("clipped result without saturated pitch");

    // An accepted transaction always starts with the octave split.
    a_accept_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_SPLIT))
        else $error("accepted transaction did not enter the split");

    // The step counter never runs past the requested step count.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_cnt <= r_split.steps))
        else $error("step counter overran");

    // The factor only grows, so the interpolation difference never goes negative.
    a_fac_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_STEP) || (r_state == S_LO)) |-> (r_cur >= r_prev))
        else $error("step factor decreased");

    // A finished result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_pitch)))
        else $error("waiting result was overwritten");

endmodule
